FILE: hdl/thread_slot_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Thread slot scheduler assertion macros
// Concurrent assertion wrappers; empty when compiled for synthesis.
// ----------------------------------------------------------------------------
`ifndef THREAD_SLOT_SCHEDULER_CORE_MACROS_SVH
`define THREAD_SLOT_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define TSS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define TSS_ASSERT_IMPLIES(lbl, ante, cons)
`define TSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// Thread slot scheduler package
// Sizes, codes, word types and the controller state type.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned THREAD_SLOTS = 16;
  localparam int unsigned SLOT_W       = $clog2(THREAD_SLOTS);
  localparam int unsigned CNT_W        = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned TICKET_MAX   = 22;
  localparam int unsigned TOT_W        = $clog2(THREAD_SLOTS * TICKET_MAX + 1);

  localparam logic [3:0]  PRIO_MAX     = 4'd10;
  localparam logic [3:0]  BEST_START   = 4'd11;
  localparam logic [3:0]  INIT_PRIO    = 4'd5;
  localparam logic [4:0]  INIT_TICKETS = 5'd10;
  localparam logic [4:0]  TICKET_BASE  = 5'd11;
  localparam logic [31:0] LCG_MUL      = 32'd1103515245;
  localparam logic [31:0] LCG_INC      = 32'd12345;
  localparam logic [3:0]  DRAW_BITS    = 4'd15;

  localparam logic [1:0] MODE_PRIO    = 2'd1;
  localparam logic [1:0] MODE_LOTTERY = 2'd2;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_status_e;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_SCHED  = 2'd2,
    REQ_EXIT   = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_RR, S_PRIO, S_PFIX, S_LSUM, S_LMUL,
    S_LADD, S_LDIV, S_LPICK, S_SWITCH, S_DONE
  } sched_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  priority_req;
    logic [31:0] seed;
  } tss_in_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] chosen_slot;
    logic       switched;
  } tss_out_t;

  typedef struct packed {
    logic [3:0] base;
    logic [3:0] aged;
    logic [4:0] tickets;
  } slot_entry_t;

  function automatic logic [3:0] slot4(logic [SLOT_W-1:0] s);
    return 4'(s);
  endfunction

endpackage

FILE: hdl/thread_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// Thread slot scheduler core
// Slot table scheduler: init, create, yield and exit with three pick rules.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid_i / in_ready_o, result words leave on
//   out_valid_o / out_ready_i; every input word yields exactly one result.
//   cfg_we_i writes the scheduling mode (round robin, priority with aging,
//   lottery); write it only while no request is in flight.
//   A lottery pick makes two sweeps over the slot memory, one LCG multiply
//   and a 15-step restoring remainder. One request is worked at a time;
//   the next is taken only once the last has left for the output register.
//   A finished result sits in the output register; the next request is
//   taken while it waits. A stalled receiver holds back the next result,
//   and with it further requests.
//   Reset marks all slots unused, running slot 0, generator state 1, mode
//   round robin. The priority/ticket memory has no reset; entries are
//   written by init and create before any read.
// ----------------------------------------------------------------------------
`include "thread_slot_scheduler_core_macros.svh"

module thread_slot_scheduler_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tss_pkg::tss_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tss_pkg::tss_out_t out_word_o
);

  localparam int unsigned N = tss_pkg::THREAD_SLOTS;
  localparam int unsigned SW = tss_pkg::SLOT_W;
  localparam int unsigned CW = tss_pkg::CNT_W;
  localparam int unsigned TW = tss_pkg::TOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(N - 1);
  localparam logic [CW-1:0] CNT_END   = CW'(N);

  // Control and slot status registers
  tss_pkg::sched_state_e state_q, state_d;
  tss_pkg::slot_status_e status_q [N];
  tss_pkg::slot_status_e status_d [N];
  logic [1:0]          mode_q;
  logic [SW-1:0]       run_q, run_d;
  logic [31:0]         rand_q, rand_d;
  logic [31:0]         prod_q, prod_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic [SW-1:0]       a_q, a_d;
  logic                rv_q, rv_d;
  logic [3:0]          prio_q, prio_d;
  logic [3:0]          best_q, best_d;
  logic [SW-1:0]       pick_q, pick_d;
  logic                pick_v_q, pick_v_d;
  logic [3:0]          pbase_q, pbase_d;
  logic [4:0]          ptick_q, ptick_d;
  logic [TW-1:0]       total_q, total_d;
  logic [TW-1:0]       sum_q, sum_d;
  logic [TW-1:0]       rem_q, rem_d;
  logic [14:0]         div_q, div_d;
  logic [3:0]          dcnt_q, dcnt_d;
  tss_pkg::tss_out_t   res_q, res_d;
  tss_pkg::tss_out_t   out_q, out_d;
  logic                ov_q, ov_d;

  // Slot memory: one write port, one registered read port
  tss_pkg::slot_entry_t mem_q [N];
  tss_pkg::slot_entry_t rd_q;
  logic                 we;
  logic [SW-1:0]        wa;
  tss_pkg::slot_entry_t wd;
  logic [SW-1:0]        ra;

  // Combinational helpers
  logic                 pass;
  logic [3:0]           aged_n;
  logic [TW-1:0]        acc;
  logic [TW:0]          sh;
  logic [3:0]           clamp;

  assign in_ready_o  = (state_q == tss_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    run_d    = run_q;
    rand_d   = rand_q;
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    prio_d   = prio_q;
    best_d   = best_q;
    pick_d   = pick_q;
    pick_v_d = pick_v_q;
    pbase_d  = pbase_q;
    ptick_d  = ptick_q;
    total_d  = total_q;
    sum_d    = sum_q;
    rem_d    = rem_q;
    div_d    = div_q;
    dcnt_d   = dcnt_q;
    res_d    = res_q;
    out_d    = out_q;
    ov_d     = ov_q;
    we       = 1'b0;
    wa       = a_q;
    wd       = rd_q;
    ra       = cnt_q[SW-1:0];
    aged_n   = '0;
    acc      = '0;
    sh       = '0;
    clamp    = (in_word_i.priority_req > tss_pkg::PRIO_MAX) ? tss_pkg::PRIO_MAX
                                                             : in_word_i.priority_req;

    // Sweep the memory: issue one read a cycle, process the registered data in the following cycle
    pass = (state_q == tss_pkg::S_PRIO) || (state_q == tss_pkg::S_LSUM) ||
           (state_q == tss_pkg::S_LPICK);
    rv_d = pass && (cnt_q < CNT_END);
    a_d  = cnt_q[SW-1:0];
    if (rv_d) begin
      cnt_d = cnt_q + CW'(1);
    end

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      tss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_word_i.req_type)
            tss_pkg::REQ_INIT: begin
              for (int i = 0; i < N; i++) begin
                status_d[i] = tss_pkg::ST_UNUSED;
              end
              status_d[0] = tss_pkg::ST_RUNNING;
              we      = 1'b1;
              wa      = '0;
              wd      = '{base: tss_pkg::INIT_PRIO, aged: tss_pkg::INIT_PRIO,
                          tickets: tss_pkg::INIT_TICKETS};
              run_d   = '0;
              rand_d  = in_word_i.seed;
              res_d   = '{ok: 1'b1, chosen_slot: 4'd0, switched: 1'b0};
              state_d = tss_pkg::S_DONE;
            end
            tss_pkg::REQ_CREATE: begin
              prio_d  = clamp;
              idx_d   = SW'(1);
              state_d = tss_pkg::S_CREATE;
            end
            default: begin
              // Exit frees the running slot, then schedules
              if (in_word_i.req_type == tss_pkg::REQ_EXIT) begin
                status_d[run_q] = tss_pkg::ST_UNUSED;
              end
              cnt_d    = '0;
              best_d   = tss_pkg::BEST_START;
              pick_v_d = 1'b0;
              total_d  = '0;
              if (mode_q == tss_pkg::MODE_PRIO) begin
                state_d = tss_pkg::S_PRIO;
              end else if (mode_q == tss_pkg::MODE_LOTTERY) begin
                state_d = tss_pkg::S_LSUM;
              end else begin
                idx_d   = (run_q == LAST_SLOT) ? '0 : run_q + SW'(1);
                state_d = tss_pkg::S_RR;
              end
            end
          endcase
        end
      end

      tss_pkg::S_CREATE: begin
        if (status_q[idx_q] == tss_pkg::ST_UNUSED) begin
          we      = 1'b1;
          wa      = idx_q;
          wd      = '{base: prio_q, aged: prio_q,
                      tickets: 5'((tss_pkg::TICKET_BASE - 5'(prio_q)) << 1)};
          status_d[idx_q] = tss_pkg::ST_READY;
          res_d   = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(idx_q), switched: 1'b0};
          state_d = tss_pkg::S_DONE;
        end else if (idx_q == LAST_SLOT) begin
          res_d   = '{ok: 1'b0, chosen_slot: 4'd0, switched: 1'b0};
          state_d = tss_pkg::S_DONE;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end

      tss_pkg::S_RR: begin
        if (status_q[idx_q] == tss_pkg::ST_READY) begin
          pick_d  = idx_q;
          state_d = tss_pkg::S_SWITCH;
        end else if (idx_q == run_q) begin
          res_d   = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(run_q), switched: 1'b0};
          state_d = tss_pkg::S_DONE;
        end else begin
          idx_d = (idx_q == LAST_SLOT) ? '0 : idx_q + SW'(1);
        end
      end

      tss_pkg::S_PRIO: begin
        if (rv_q && status_q[a_q] == tss_pkg::ST_READY) begin
          aged_n = (rd_q.aged == 4'd0) ? 4'd0 : rd_q.aged - 4'd1;
          if (rd_q.aged != 4'd0) begin
            we = 1'b1;
            wd = '{base: rd_q.base, aged: aged_n, tickets: rd_q.tickets};
          end
          if (aged_n < best_q) begin
            best_d   = aged_n;
            pick_d   = a_q;
            pick_v_d = 1'b1;
            pbase_d  = rd_q.base;
            ptick_d  = rd_q.tickets;
          end
        end
        if (cnt_q == CNT_END && !rv_q) begin
          if (pick_v_q) begin
            state_d = tss_pkg::S_PFIX;
          end else begin
            res_d   = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(run_q), switched: 1'b0};
            state_d = tss_pkg::S_DONE;
          end
        end
      end

      tss_pkg::S_PFIX: begin
        // Reset the winner's aged priority to its base
        we      = 1'b1;
        wa      = pick_q;
        wd      = '{base: pbase_q, aged: pbase_q, tickets: ptick_q};
        state_d = tss_pkg::S_SWITCH;
      end

      tss_pkg::S_LSUM: begin
        if (rv_q && status_q[a_q] == tss_pkg::ST_READY) begin
          total_d = total_q + TW'(rd_q.tickets);
        end
        if (cnt_q == CNT_END && !rv_q) begin
          if (total_q == '0) begin
            res_d   = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(run_q), switched: 1'b0};
            state_d = tss_pkg::S_DONE;
          end else begin
            state_d = tss_pkg::S_LMUL;
          end
        end
      end

      tss_pkg::S_LMUL: begin
        prod_d  = rand_q * tss_pkg::LCG_MUL;
        state_d = tss_pkg::S_LADD;
      end

      tss_pkg::S_LADD: begin
        rand_d  = prod_q + tss_pkg::LCG_INC;
        div_d   = rand_d[30:16];
        rem_d   = '0;
        dcnt_d  = tss_pkg::DRAW_BITS;
        state_d = tss_pkg::S_LDIV;
      end

      tss_pkg::S_LDIV: begin
        // Restoring remainder, one bit a cycle
        sh = {rem_q, div_q[14]};
        if (sh >= {1'b0, total_q}) begin
          rem_d = TW'(sh - {1'b0, total_q});
        end else begin
          rem_d = sh[TW-1:0];
        end
        div_d  = div_q << 1;
        dcnt_d = dcnt_q - 4'd1;
        if (dcnt_q == 4'd1) begin
          cnt_d    = '0;
          sum_d    = '0;
          pick_v_d = 1'b0;
          state_d  = tss_pkg::S_LPICK;
        end
      end

      tss_pkg::S_LPICK: begin
        if (rv_q && status_q[a_q] == tss_pkg::ST_READY && !pick_v_q) begin
          acc   = sum_q + TW'(rd_q.tickets);
          sum_d = acc;
          if (acc > rem_q) begin
            pick_d   = a_q;
            pick_v_d = 1'b1;
          end
        end
        if (cnt_q == CNT_END && !rv_q) begin
          state_d = tss_pkg::S_SWITCH;
        end
      end

      tss_pkg::S_SWITCH: begin
        if (pick_q == run_q && status_q[run_q] == tss_pkg::ST_RUNNING) begin
          res_d = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(run_q), switched: 1'b0};
        end else begin
          if (status_q[run_q] != tss_pkg::ST_UNUSED) begin
            status_d[run_q] = tss_pkg::ST_READY;
          end
          status_d[pick_q] = tss_pkg::ST_RUNNING;
          run_d = pick_q;
          res_d = '{ok: 1'b1, chosen_slot: tss_pkg::slot4(pick_q),
                    switched: (pick_q != run_q)};
        end
        state_d = tss_pkg::S_DONE;
      end

      tss_pkg::S_DONE: begin
        // Hold until the output register is free
        if (!ov_q || out_ready_i) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = tss_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tss_pkg::S_IDLE;
      for (int i = 0; i < N; i++) begin
        status_q[i] <= tss_pkg::ST_UNUSED;
      end
      mode_q   <= '0;
      run_q    <= '0;
      rand_q   <= 32'd1;
      prod_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      a_q      <= '0;
      rv_q     <= 1'b0;
      prio_q   <= '0;
      best_q   <= '0;
      pick_q   <= '0;
      pick_v_q <= 1'b0;
      pbase_q  <= '0;
      ptick_q  <= '0;
      total_q  <= '0;
      sum_q    <= '0;
      rem_q    <= '0;
      div_q    <= '0;
      dcnt_q   <= '0;
      res_q    <= '0;
      out_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      run_q    <= run_d;
      rand_q   <= rand_d;
      prod_q   <= prod_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      a_q      <= a_d;
      rv_q     <= rv_d;
      prio_q   <= prio_d;
      best_q   <= best_d;
      pick_q   <= pick_d;
      pick_v_q <= pick_v_d;
      pbase_q  <= pbase_d;
      ptick_q  <= ptick_d;
      total_q  <= total_d;
      sum_q    <= sum_d;
      rem_q    <= rem_d;
      div_q    <= div_d;
      dcnt_q   <= dcnt_d;
      res_q    <= res_d;
      out_q    <= out_d;
      ov_q     <= ov_d;
    end
  end

  // An accepted request always leaves idle
  `TSS_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, state_q != tss_pkg::S_IDLE)
  // The lottery draw is reduced below the ticket total before the pick sweep
  `TSS_ASSERT_IMPLIES(a_draw_range, state_q == tss_pkg::S_LPICK, rem_q < total_q)
  // After a switch the running slot is marked running
  `TSS_ASSERT_NEXT(a_switch_run, state_q == tss_pkg::S_SWITCH,
                   status_q[run_q] == tss_pkg::ST_RUNNING)

endmodule

FILE: test/tss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread slot scheduler checker
// Watches both channels, keeps its own slot table and compares each result.
// ----------------------------------------------------------------------------
module tss_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  tss_pkg::tss_in_t  in_word_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  tss_pkg::tss_out_t out_word_o,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int NS = tss_pkg::THREAD_SLOTS;

  tss_pkg::slot_status_e state_q [NS];
  logic [3:0]   base_q [NS];
  logic [3:0]   aged_q [NS];
  logic [4:0]   tix_q [NS];
  int unsigned  cur_q;
  logic [31:0]  lcg_q;
  logic [1:0]   mode_q;
  tss_pkg::tss_out_t sched_results_q [$];

  assign pending_o = sched_results_q.size();

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < NS; i++) begin
      state_q[i] = tss_pkg::ST_UNUSED;
      base_q[i] = '0;
      aged_q[i] = '0;
      tix_q[i] = '0;
    end
    cur_q = 0;
    lcg_q = 32'd1;
    mode_q = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Pick the next slot under the current mode; -1 when none is ready.
  function automatic int pick_slot();
    int pick;
    int unsigned best, total, winner, sum, idx;
    pick = -1;
    if (mode_q == tss_pkg::MODE_PRIO) begin
      best = 11;
      for (int i = 0; i < NS; i++)
        if (state_q[i] == tss_pkg::ST_READY && aged_q[i] > 0) aged_q[i]--;
      for (int i = 0; i < NS; i++)
        if (state_q[i] == tss_pkg::ST_READY && aged_q[i] < best) begin
          best = aged_q[i];
          pick = i;
        end
      if (pick >= 0) aged_q[pick] = base_q[pick];
    end else if (mode_q == tss_pkg::MODE_LOTTERY) begin
      total = 0;
      sum = 0;
      for (int i = 0; i < NS; i++)
        if (state_q[i] == tss_pkg::ST_READY) total += tix_q[i];
      if (total > 0) begin
        lcg_q = lcg_q * tss_pkg::LCG_MUL + tss_pkg::LCG_INC;
        winner = ((lcg_q >> 16) % 32768) % total;
        for (int i = 0; i < NS; i++)
          if (state_q[i] == tss_pkg::ST_READY) begin
            sum += tix_q[i];
            if (sum > winner) begin
              pick = i;
              break;
            end
          end
      end
    end else begin
      for (int k = 1; k <= NS; k++) begin
        idx = (cur_q + k) % NS;
        if (state_q[idx] == tss_pkg::ST_READY) begin
          pick = idx;
          break;
        end
        if (idx == cur_q) break;
      end
    end
    return pick;
  endfunction

  function automatic tss_pkg::tss_out_t predict_result(tss_pkg::tss_in_t w);
    tss_pkg::tss_out_t r;
    int pick;
    int unsigned prev;
    logic [3:0] p;
    r = '{ok: 1'b1, chosen_slot: 4'd0, switched: 1'b0};
    case (tss_pkg::req_type_e'(w.req_type))
      tss_pkg::REQ_INIT: begin
        for (int i = 0; i < NS; i++) state_q[i] = tss_pkg::ST_UNUSED;
        state_q[0] = tss_pkg::ST_RUNNING;
        base_q[0] = tss_pkg::INIT_PRIO;
        aged_q[0] = tss_pkg::INIT_PRIO;
        tix_q[0] = tss_pkg::INIT_TICKETS;
        cur_q = 0;
        lcg_q = w.seed;
      end
      tss_pkg::REQ_CREATE: begin
        r.ok = 1'b0;
        for (int i = 1; i < NS; i++)
          if (state_q[i] == tss_pkg::ST_UNUSED) begin
            p = (w.priority_req > tss_pkg::PRIO_MAX) ? tss_pkg::PRIO_MAX : w.priority_req;
            base_q[i] = p;
            aged_q[i] = p;
            tix_q[i] = 5'((11 - p) * 2);
            state_q[i] = tss_pkg::ST_READY;
            r.ok = 1'b1;
            r.chosen_slot = 4'(i);
            break;
          end
      end
      default: begin
        if (tss_pkg::req_type_e'(w.req_type) == tss_pkg::REQ_EXIT)
          state_q[cur_q] = tss_pkg::ST_UNUSED;
        prev = cur_q;
        pick = pick_slot();
        if (pick >= 0 && !(pick == prev && state_q[prev] == tss_pkg::ST_RUNNING)) begin
          if (state_q[prev] != tss_pkg::ST_UNUSED) state_q[prev] = tss_pkg::ST_READY;
          state_q[pick] = tss_pkg::ST_RUNNING;
          cur_q = pick;
          r.switched = (cur_q != prev);
        end
        r.chosen_slot = 4'(cur_q);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    tss_pkg::tss_out_t want;
    if (rst_ni) begin
      if (cfg_we_i) mode_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o) sched_results_q.push_back(predict_result(in_word_i));
      if (out_valid_o && out_ready_i) begin
        if (sched_results_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = sched_results_q.pop_front();
          if (out_word_o.ok !== want.ok) report_mismatch("ok", out_word_o.ok, want.ok);
          if (out_word_o.chosen_slot !== want.chosen_slot)
            report_mismatch("chosen_slot", out_word_o.chosen_slot, want.chosen_slot);
          if (out_word_o.switched !== want.switched)
            report_mismatch("switched", out_word_o.switched, want.switched);
        end
      end
    end
  end
endmodule

FILE: test/tb_thread_slot_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread slot scheduler testbench
// Drives directed and random request words through all three pick modes
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_thread_slot_scheduler_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic     in_valid_i;
  logic     in_ready_o;
  tss_pkg::tss_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tss_pkg::tss_out_t out_word_o;
  int       fail_count;
  int       pending;
  int       idle_cycles;
  bit       hold_off;  // long receiver stall, requested by the stimulus process

  thread_slot_scheduler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  tss_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive all inputs known from time zero; hold reset, then release it at a falling edge.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Receiver: stall on its own pattern of phases - always ready, light
  // random stalls, heavy stalls - and once drop ready for a long stretch.
  initial begin
    int phase_len, phase_kind;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      phase_len = $urandom_range(10, 200);
      phase_kind = $urandom_range(0, 2);
      repeat (phase_len) begin
        @(negedge clk_i);
        if (hold_off && !held) begin
          out_ready_i = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          held = 1'b1;
        end
        if (phase_kind == 0) out_ready_i = 1'b1;
        else if (phase_kind == 1) out_ready_i = ($urandom_range(0, 3) != 0);
        else out_ready_i = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog: count cycles with no word accepted on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one word and hold it until it is accepted; valid stays up if
  // the next word follows back to back (no gap).
  int burst_left;
  task automatic send_word(input tss_pkg::req_type_e req, input logic [3:0] prio,
                           input logic [31:0] seed);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i = 1'b1;
    in_word_i = '{req_type: req, priority_req: prio, seed: seed};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Wait until every result is back, then let in-flight work settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    cfg_we_i = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random request mix: mostly create and schedule, some exits, rare init.
  task automatic random_word();
    int sel;
    tss_pkg::req_type_e req;
    sel = $urandom_range(0, 99);
    if (sel < 3) req = tss_pkg::REQ_INIT;
    else if (sel < 33) req = tss_pkg::REQ_CREATE;
    else if (sel < 78) req = tss_pkg::REQ_SCHED;
    else req = tss_pkg::REQ_EXIT;
    send_word(req, 4'($urandom_range(0, 15)), $urandom());
  endtask

  initial begin
    logic [1:0] modes [6];
    modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1};
    burst_left = 0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed: requests before any init work on the all-unused table.
    send_word(tss_pkg::REQ_SCHED, 4'd0, 32'd0);
    send_word(tss_pkg::REQ_EXIT, 4'd0, 32'd0);
    send_word(tss_pkg::REQ_CREATE, 4'd15, 32'd0);
    send_word(tss_pkg::REQ_SCHED, 4'd0, 32'd0);
    send_word(tss_pkg::REQ_INIT, 4'hF, 32'hFFFF_FFFF);
    // Fill every slot (extremes of priority, clamp above 10), then overflow.
    for (int i = 1; i < tss_pkg::THREAD_SLOTS; i++)
      send_word(tss_pkg::REQ_CREATE, (i % 2) ? 4'd0 : 4'(i), 32'd0);
    send_word(tss_pkg::REQ_CREATE, 4'd3, 32'd0);
    send_word(tss_pkg::REQ_SCHED, 4'd0, 32'd0);
    send_word(tss_pkg::REQ_EXIT, 4'd0, 32'd0);
    send_word(tss_pkg::REQ_INIT, 4'd0, 32'd0);
    // Exit the only thread: nothing runnable.
    send_word(tss_pkg::REQ_EXIT, 4'd0, 32'd0);
    drain();

    // Random phases over every mode, including the unused value 3.
    foreach (modes[m]) begin
      write_mode(modes[m]);
      send_word(tss_pkg::REQ_INIT, 4'd0, $urandom());
      for (int n = 0; n < 270; n++) begin
        // Ask the receiver for its long hold-off while words keep coming.
        if (m == 2 && n == 100) hold_off = 1'b1;
        random_word();
      end
      drain();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
